// ----- rtl/indexed_bit_shift_executor_assert.svh -----
// Assertion macros used by the checker file of the indexed bit-shift executor.
`ifndef INDEXED_BIT_SHIFT_EXECUTOR_ASSERT_SVH
`define INDEXED_BIT_SHIFT_EXECUTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IBSE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ibse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IBSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibse assertion failed");

`endif

// ----- rtl/ibse_pkg.sv -----
// Types and constants of the indexed bit-shift executor.
package ibse_pkg;

   localparam int unsigned AddrWidth  = 16;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned TimeWidth  = 5;

   localparam logic [TimeWidth-1:0] TStatesBit = 5'd20;
   localparam logic [TimeWidth-1:0] TStatesRmw = 5'd23;
   localparam logic [TimeWidth-1:0] TStatesNone = 5'd0;

   // Flag bit positions.
   localparam int unsigned FlagC = 0;
   localparam int unsigned FlagN = 1;
   localparam int unsigned FlagP = 2;
   localparam int unsigned FlagH = 4;
   localparam int unsigned FlagZ = 6;
   localparam int unsigned FlagS = 7;

   localparam logic [2:0] OpLowCode   = 3'd6;
   localparam logic [7:0] OpIllegalSll = 8'h36;

   localparam logic [1:0] GroupShift = 2'd0;
   localparam logic [1:0] GroupBit   = 2'd1;
   localparam logic [1:0] GroupRes   = 2'd2;
   localparam logic [1:0] GroupSet   = 2'd3;

   localparam logic [2:0] SelBit7 = 3'd7;

   typedef enum logic [3:0] {
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL,
      OP_BIT, OP_RES, OP_SET, OP_TRAP
   } op_type;

   typedef struct packed {
      logic [AddrWidth-1:0] addr;
      op_type               op;
      logic [2:0]           sel;
      logic [ByteWidth-1:0] mem_byte;
      logic [ByteWidth-1:0] flags_in;
   } dec_type;

   typedef struct packed {
      logic [AddrWidth-1:0] addr;
      op_type               op;
      logic [2:0]           sel;
      logic [ByteWidth-1:0] res_byte;
      logic                 carry;
      logic                 bit_set;
      logic [ByteWidth-1:0] flags_in;
   } exe_type;

   typedef struct packed {
      logic [AddrWidth-1:0] target_address;
      logic                 write_strobe;
      logic [ByteWidth-1:0] write_byte;
      logic [ByteWidth-1:0] flags_out;
      logic [TimeWidth-1:0] t_states;
      logic                 illegal_trap;
   } rsp_type;

endpackage

// ----- rtl/ibse_req_if.sv -----
// Instruction operand channel of the indexed bit-shift executor.
interface ibse_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        sub_opcode;
   logic signed [7:0] displacement;
   logic [15:0]       index_base;
   logic [7:0]        mem_byte;
   logic [7:0]        flags_in;

   modport source (output valid, sub_opcode, displacement, index_base, mem_byte,
                   flags_in, input ready);
   modport sink (input valid, sub_opcode, displacement, index_base, mem_byte,
                 flags_in, output ready);
endinterface

// ----- rtl/ibse_rsp_if.sv -----
// Result channel of the indexed bit-shift executor.
interface ibse_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] target_address;
   logic        write_strobe;
   logic [7:0]  write_byte;
   logic [7:0]  flags_out;
   logic [4:0]  t_states;
   logic        illegal_trap;

   modport source (output valid, target_address, write_strobe, write_byte,
                   flags_out, t_states, illegal_trap, input ready);
   modport sink (input valid, target_address, write_strobe, write_byte,
                 flags_out, t_states, illegal_trap, output ready);
endinterface

// ----- rtl/ibse_decode.sv -----
// First stage: forms the target address and decodes the sub-opcode.
module ibse_decode (
   input  logic             clock,
   input  logic             reset,
   ibse_req_if.sink         req,
   output logic             dn_valid,
   input  logic             dn_ready,
   output ibse_pkg::dec_type dn_data
);
   import ibse_pkg::*;

   logic    valid_ff;
   logic    advance;
   dec_type data_ff;
   dec_type data_in;
   logic [1:0] group;
   logic [2:0] sel;

   assign advance   = !valid_ff || dn_ready;
   assign req.ready = advance;
   assign dn_valid  = valid_ff;
   assign dn_data   = data_ff;

   assign group = req.sub_opcode[7:6];
   assign sel   = req.sub_opcode[5:3];

   always_comb begin
      data_in.addr     = req.index_base
                         + {{(AddrWidth-ByteWidth){req.displacement[7]}},
                            req.displacement};
      data_in.sel      = sel;
      data_in.mem_byte = req.mem_byte;
      data_in.flags_in = req.flags_in;
      if (req.sub_opcode[2:0] != OpLowCode || req.sub_opcode == OpIllegalSll) begin
         data_in.op = OP_TRAP;
      end else begin
         case (group)
            GroupShift: begin
               case (sel)
                  3'd0:    data_in.op = OP_RLC;
                  3'd1:    data_in.op = OP_RRC;
                  3'd2:    data_in.op = OP_RL;
                  3'd3:    data_in.op = OP_RR;
                  3'd4:    data_in.op = OP_SLA;
                  3'd5:    data_in.op = OP_SRA;
                  3'd7:    data_in.op = OP_SRL;
                  default: data_in.op = OP_TRAP;
               endcase
            end
            GroupBit: data_in.op = OP_BIT;
            GroupRes: data_in.op = OP_RES;
            GroupSet: data_in.op = OP_SET;
            default:  data_in.op = OP_TRAP;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req.valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/ibse_execute.sv -----
// Second stage: rotates, shifts or masks the memory byte.
module ibse_execute (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  ibse_pkg::dec_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output ibse_pkg::exe_type dn_data
);
   import ibse_pkg::*;

   logic    valid_ff;
   exe_type data_ff;
   exe_type data_in;
   logic [ByteWidth-1:0] v;
   logic [ByteWidth-1:0] mask;
   logic cin;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   assign v    = up_data.mem_byte;
   assign cin  = up_data.flags_in[FlagC];
   assign mask = ByteWidth'(1) << up_data.sel;

   always_comb begin
      data_in.addr     = up_data.addr;
      data_in.op       = up_data.op;
      data_in.sel      = up_data.sel;
      data_in.flags_in = up_data.flags_in;
      data_in.bit_set  = |(v & mask);
      data_in.carry    = 1'b0;
      data_in.res_byte = '0;
      case (up_data.op)
         OP_RLC: begin
            data_in.carry    = v[7];
            data_in.res_byte = {v[6:0], v[7]};
         end
         OP_RRC: begin
            data_in.carry    = v[0];
            data_in.res_byte = {v[0], v[7:1]};
         end
         OP_RL: begin
            data_in.carry    = v[7];
            data_in.res_byte = {v[6:0], cin};
         end
         OP_RR: begin
            data_in.carry    = v[0];
            data_in.res_byte = {cin, v[7:1]};
         end
         OP_SLA: begin
            data_in.carry    = v[7];
            data_in.res_byte = {v[6:0], 1'b0};
         end
         OP_SRA: begin
            data_in.carry    = v[0];
            data_in.res_byte = {v[7], v[7:1]};
         end
         OP_SRL: begin
            data_in.carry    = v[0];
            data_in.res_byte = {1'b0, v[7:1]};
         end
         OP_RES:  data_in.res_byte = v & ~mask;
         OP_SET:  data_in.res_byte = v | mask;
         default: data_in.res_byte = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/ibse_retire.sv -----
// Third stage: builds the new flags and holds the result word for the sink.
module ibse_retire (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  ibse_pkg::exe_type up_data,
   ibse_rsp_if.source        rsp
);
   import ibse_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;
   logic [ByteWidth-1:0] r;
   logic [ByteWidth-1:0] f;

   assign up_ready  = !valid_ff || rsp.ready;
   assign rsp.valid = valid_ff;
   assign rsp.target_address = data_ff.target_address;
   assign rsp.write_strobe   = data_ff.write_strobe;
   assign rsp.write_byte     = data_ff.write_byte;
   assign rsp.flags_out      = data_ff.flags_out;
   assign rsp.t_states       = data_ff.t_states;
   assign rsp.illegal_trap   = data_ff.illegal_trap;

   assign r = up_data.res_byte;
   assign f = up_data.flags_in;

   always_comb begin
      data_in.target_address = up_data.addr;
      data_in.write_byte     = r;
      data_in.flags_out      = f;
      data_in.write_strobe   = 1'b1;
      data_in.t_states       = TStatesRmw;
      data_in.illegal_trap   = 1'b0;
      case (up_data.op)
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
            data_in.flags_out        = f & 8'h28;
            data_in.flags_out[FlagC] = up_data.carry;
            data_in.flags_out[FlagZ] = (r == '0);
            data_in.flags_out[FlagS] = r[7];
            data_in.flags_out[FlagP] = ~^r;
         end
         OP_BIT: begin
            // Z and P/V both mirror the inverted tested bit; S only on bit 7.
            data_in.flags_out[FlagH] = 1'b1;
            data_in.flags_out[FlagN] = 1'b0;
            data_in.flags_out[FlagZ] = !up_data.bit_set;
            data_in.flags_out[FlagP] = !up_data.bit_set;
            data_in.flags_out[FlagS] = up_data.bit_set && (up_data.sel == SelBit7);
            data_in.write_strobe     = 1'b0;
            data_in.t_states         = TStatesBit;
         end
         OP_RES, OP_SET: begin
            data_in.flags_out = f;
         end
         default: begin
            data_in.write_strobe = 1'b0;
            data_in.t_states     = TStatesNone;
            data_in.illegal_trap = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/indexed_bit_shift_executor.sv -----
// Top level of the indexed bit-shift executor: three-stage pipeline.
//
//   Channel  Dir  Handshake      Word
//   req_bus  in   valid/ready    sub_opcode, displacement, index_base, mem_byte, flags_in
//   rsp_bus  out  valid/ready    target_address, write_strobe, write_byte, flags_out,
//                                t_states, illegal_trap
//
// One word is accepted per cycle while rsp_bus does not stall; each result passes
// through the decode, execute and retire registers, in that order, before it
// shows on rsp_bus.
// Reset clears the valid bits of all three stages; payload registers are not reset.
// A stage holds its word while the one after it is full and stalled, so a stall
// on rsp_bus backs up stage by stage and never drops or repeats a word.
module indexed_bit_shift_executor (
   input  logic       clock,
   input  logic       reset,
   ibse_req_if.sink   req_bus,
   ibse_rsp_if.source rsp_bus
);
   import ibse_pkg::*;

   logic    dec_valid;
   logic    dec_ready;
   dec_type dec_data;
   logic    exe_valid;
   logic    exe_ready;
   exe_type exe_data;

   ibse_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .dn_valid (dec_valid),
      .dn_ready (dec_ready),
      .dn_data  (dec_data)
   );

   ibse_execute u_execute (
      .clock    (clock),
      .reset    (reset),
      .up_valid (dec_valid),
      .up_ready (dec_ready),
      .up_data  (dec_data),
      .dn_valid (exe_valid),
      .dn_ready (exe_ready),
      .dn_data  (exe_data)
   );

   ibse_retire u_retire (
      .clock    (clock),
      .reset    (reset),
      .up_valid (exe_valid),
      .up_ready (exe_ready),
      .up_data  (exe_data),
      .rsp      (rsp_bus)
   );

endmodule

// ----- rtl/ibse_checker.sv -----
// Port-level checker of the indexed bit-shift executor and its bind.
`include "indexed_bit_shift_executor_assert.svh"

module ibse_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       write_strobe,
   input logic [7:0] write_byte,
   input logic [7:0] flags_out,
   input logic [4:0] t_states,
   input logic       illegal_trap
);
   import ibse_pkg::*;

   // A trapped word writes nothing and takes no time.
   `IBSE_ASSERT_SAME(a_trap_quiet, clock, reset, rsp_valid && illegal_trap, !write_strobe && write_byte == '0 && t_states == TStatesNone)

   // Writes take the read-modify-write time; a bit test takes the shorter one.
   `IBSE_ASSERT_SAME(a_time_class, clock, reset, rsp_valid && !illegal_trap, (write_strobe && t_states == TStatesRmw) || (!write_strobe && t_states == TStatesBit))

   // A bit test always sets H, clears N and reports Z equal to P/V.
   `IBSE_ASSERT_SAME(a_bit_flags, clock, reset, rsp_valid && !illegal_trap && !write_strobe, flags_out[FlagH] && !flags_out[FlagN] && flags_out[FlagZ] == flags_out[FlagP])

   // A stalled result word stays offered.
   `IBSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind indexed_bit_shift_executor ibse_checker u_ibse_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .write_strobe (rsp_bus.write_strobe),
   .write_byte   (rsp_bus.write_byte),
   .flags_out    (rsp_bus.flags_out),
   .t_states     (rsp_bus.t_states),
   .illegal_trap (rsp_bus.illegal_trap)
);
